[design/dsrm_pkg.sv]
// ----------------------------------------------------------------------------
// dsrm_pkg
// Shared constants, symbol codes, word layout types and helper functions
// for the dot-star pattern matcher.
// ----------------------------------------------------------------------------
package dsrm_pkg;

   localparam int MaxPattern = 16;
   localparam int RowWidth   = MaxPattern + 1;
   localparam int CountWidth = $clog2(MaxPattern + 1);
   localparam int IdxWidth   = $clog2(MaxPattern);
   localparam int SymWidth   = 5;
   localparam int ActWidth   = 2;
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 8;

   // symbol codes
   localparam logic [SymWidth-1:0] SYM_DOT  = SymWidth'(26);
   localparam logic [SymWidth-1:0] SYM_STAR = SymWidth'(27);

   // action codes
   localparam logic [ActWidth-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ActWidth-1:0] ACT_APPEND = 2'd1;
   localparam logic [ActWidth-1:0] ACT_START  = 2'd2;
   localparam logic [ActWidth-1:0] ACT_TEXT   = 2'd3;

   typedef logic [SymWidth-1:0]   sym_type;
   typedef logic [RowWidth-1:0]   row_type;
   typedef logic [CountWidth-1:0] count_type;

   // neighbor bits one column of the match row needs
   typedef struct packed {
      logic row_here;    // old row, this column
      logic row_left;    // old row, one column left
      logic adv_left1;   // new row, one column left
      logic adv_left2;   // new row, two columns left
      logic emp_left2;   // empty-text row, two columns left
   } dsrm_link_type;

   // pattern element accepts text symbol
   function automatic logic elem_accepts(input sym_type e, input sym_type t);
      logic ok;
      if (e == SYM_DOT) begin
         ok = 1'b1;
      end else if (e == SYM_STAR) begin
         ok = 1'b0;
      end else begin
         ok = (e == t);
      end
      return ok;
   endfunction

   // one bit per column that lies within a pattern of length n
   function automatic row_type col_mask(input count_type n);
      row_type m;
      for (int i = 0; i < RowWidth; i++) begin
         m[i] = (CountWidth'(i) <= n);
      end
      return m;
   endfunction

endpackage

[design/dsrm_cell.sv]
// ----------------------------------------------------------------------------
// dsrm_cell
// One column of the match row: next-row bit for a text symbol and the
// empty-text bit, from the pattern element at this column and its left.
// ----------------------------------------------------------------------------
module dsrm_cell (
   input  dsrm_pkg::sym_type       cur_sym,
   input  dsrm_pkg::sym_type       prev_sym,
   input  dsrm_pkg::sym_type       text_sym,
   input  logic                    has_prev,
   input  dsrm_pkg::dsrm_link_type link,
   output logic                    adv_bit,
   output logic                    emp_bit
);
   import dsrm_pkg::*;

   logic is_star;
   logic rep;

   assign is_star = (cur_sym == SYM_STAR);

   // star repeats the element on its left once more
   assign rep = elem_accepts(prev_sym, text_sym) & (link.row_here | link.adv_left1);

   always_comb begin
      if (is_star) begin
         // leading star matches nothing
         adv_bit = has_prev & (link.adv_left2 | rep);
         emp_bit = has_prev & link.emp_left2;
      end else begin
         adv_bit = link.row_left & elem_accepts(cur_sym, text_sym);
         emp_bit = 1'b0;
      end
   end

endmodule

[design/dot_star_regex_matcher.sv]
// ----------------------------------------------------------------------------
// dot_star_regex_matcher
// Whole-text matcher for patterns of letters, '.' and '*'.
// ----------------------------------------------------------------------------
// Usage: send words on the req_ stream; tuser carries the action (clear
// pattern, append pattern symbol, start new text, text symbol) and tdata the
// symbol. Every word returns exactly one rsp_ word: matched says whether the
// text since the last start/clear/append matches the whole loaded pattern,
// overflow flags an append dropped because the 16-entry store is full.
// Any pattern change restarts the text. A word is taken every cycle unless
// the rsp_ side stalls; each result passes the input register and then the
// result register, and the clock is set by the one-bit ripple across the 16
// columns of the match row plus the final column select.
// ----------------------------------------------------------------------------
module dot_star_regex_matcher (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [dsrm_pkg::ReqDataWidth-1:0] req_tdata,  // [4:0] symbol
   input  logic [dsrm_pkg::ActWidth-1:0]     req_tuser,  // [1:0] action
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [dsrm_pkg::RspDataWidth-1:0] rsp_tdata   // [0] matched, [1] overflow
);
   import dsrm_pkg::*;

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   logic [ActWidth-1:0] act_ff;
   sym_type             sym_ff;
   logic                req_accept;
   logic                s1_advance;

   // result stage
   logic rsp_valid_ff;
   logic matched_ff, matched_in;
   logic ovf_ff, ovf_in;

   // block state
   sym_type   store_ff [MaxPattern];
   sym_type   store_view [MaxPattern];
   count_type count_ff, count_in;
   row_type   row_ff, row_in;

   logic    store_full;
   logic    store_we;
   row_type adv;
   row_type emp;

   // --- handshake ---------------------------------------------------------
   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_advance;
   assign req_accept = req_tvalid & req_tready;
   assign s1_valid_in = req_accept | (s1_valid_ff & ~s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff <= req_tuser;
         sym_ff <= req_tdata[SymWidth-1:0];
      end
   end

   // --- pattern count and overflow ----------------------------------------
   assign store_full = (count_ff == CountWidth'(MaxPattern));
   assign store_we   = (act_ff == ACT_APPEND) & ~store_full;

   always_comb begin
      count_in = count_ff;
      ovf_in   = 1'b0;
      case (act_ff)
         ACT_CLEAR: begin
            count_in = '0;
         end
         ACT_APPEND: begin
            if (store_full) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + CountWidth'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // store as seen after this word's append
   always_comb begin
      for (int i = 0; i < MaxPattern; i++) begin
         store_view[i] = store_ff[i];
      end
      if (store_we) begin
         store_view[count_ff[IdxWidth-1:0]] = sym_ff;
      end
   end

   // --- match row columns -------------------------------------------------
   // column 0: empty pattern matches only empty text
   assign adv[0] = 1'b0;
   assign emp[0] = 1'b1;

   for (genvar c = 1; c < RowWidth; c++) begin : g_col
      dsrm_link_type link;
      if (c == 1) begin : g_first
         assign link = '{row_here: row_ff[c], row_left: row_ff[c-1],
                         adv_left1: adv[c-1], adv_left2: 1'b0, emp_left2: 1'b0};
         dsrm_cell u_cell (
            .cur_sym  (store_view[c-1]),
            .prev_sym ('0),
            .text_sym (sym_ff),
            .has_prev (1'b0),
            .link     (link),
            .adv_bit  (adv[c]),
            .emp_bit  (emp[c])
         );
      end else begin : g_rest
         assign link = '{row_here: row_ff[c], row_left: row_ff[c-1],
                         adv_left1: adv[c-1], adv_left2: adv[c-2],
                         emp_left2: emp[c-2]};
         dsrm_cell u_cell (
            .cur_sym  (store_view[c-1]),
            .prev_sym (store_view[c-2]),
            .text_sym (sym_ff),
            .has_prev (1'b1),
            .link     (link),
            .adv_bit  (adv[c]),
            .emp_bit  (emp[c])
         );
      end
   end

   // columns past the pattern end are cleared
   assign row_in     = ((act_ff == ACT_TEXT) ? adv : emp) & col_mask(count_in);
   assign matched_in = row_in[count_in];

   // --- state update ------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         row_ff   <= row_type'(1);
      end else if (s1_advance) begin
         count_ff <= count_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && store_we) begin
         store_ff[count_ff[IdxWidth-1:0]] <= sym_ff;
      end
   end

   // --- result register ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         matched_ff <= matched_in;
         ovf_ff     <= ovf_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-2){1'b0}}, ovf_ff, matched_ff};

   // --- checks ------------------------------------------------------------
   // a pending result agrees with the state it left behind
   a_matched_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> matched_ff == row_ff[count_ff])
      else $error("matched bit disagrees with match row");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ovf_ff |-> count_ff == CountWidth'(MaxPattern))
      else $error("overflow reported with room in store");

   a_row_tail: assert property (@(posedge clock) disable iff (reset)
      (row_ff & ~col_mask(count_ff)) == '0)
      else $error("match row bit set past pattern end");

   // text words clear column 0, every other word restarts it
   a_row_origin: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> row_ff[0] == ($past(act_ff) != ACT_TEXT))
      else $error("column 0 of match row wrong");

endmodule
